// ===== src/box_region_table_point_locate_defines.svh =====
// Assertion macros shared by the box region table RTL.
`ifndef BOX_REGION_TABLE_POINT_LOCATE_DEFINES_SVH
`define BOX_REGION_TABLE_POINT_LOCATE_DEFINES_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define BRTPL_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Checks that a consequent holds in the same cycle as its antecedent.
`define BRTPL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define BRTPL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/brtpl_pkg.sv =====
// Shared types and constants of the box region table.
`default_nettype none

package brtpl_pkg;

  // Fixed field widths of the channels and the configuration port.
  localparam int unsigned FW        = 16;
  localparam int unsigned GW        = 17;
  localparam int unsigned SIDX_W    = 4;
  localparam int unsigned BIDX_W    = 4;
  localparam int unsigned ST_W      = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned AXES      = 3;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_LOCATE = 1'b1;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_BOX   = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_START = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_Z = 2'd2;

  localparam logic [GW-1:0] GRID_RESET = 17'd65536;

  // One axis of a range check: lo <= val <= hi.
  typedef struct packed {
    logic [GW-1:0] lo;
    logic [GW-1:0] val;
    logic [GW-1:0] hi;
  } span_t;

  typedef span_t [AXES-1:0] span_set_t;

endpackage

`default_nettype wire

// ===== src/brtpl_in_if.sv =====
// Input channel of the box region table: one add or locate item per transfer.
`default_nettype none

interface brtpl_in_if;
  import brtpl_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [FW-1:0]     box_x_first;
  logic [FW-1:0]     box_x_last;
  logic [FW-1:0]     box_y_first;
  logic [FW-1:0]     box_y_last;
  logic [FW-1:0]     box_z_first;
  logic [FW-1:0]     box_z_last;
  logic [FW-1:0]     point_x;
  logic [FW-1:0]     point_y;
  logic [FW-1:0]     point_z;
  logic [SIDX_W-1:0] start_index;

  modport source (
    output valid, opcode, box_x_first, box_x_last, box_y_first, box_y_last,
           box_z_first, box_z_last, point_x, point_y, point_z, start_index,
    input  ready
  );

  modport sink (
    input  valid, opcode, box_x_first, box_x_last, box_y_first, box_y_last,
           box_z_first, box_z_last, point_x, point_y, point_z, start_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/brtpl_out_if.sv =====
// Result channel of the box region table: status and entry index per transfer.
`default_nettype none

interface brtpl_out_if;
  import brtpl_pkg::*;

  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [BIDX_W-1:0] block_index;

  modport source (
    output valid, status, block_index,
    input  ready
  );

  modport sink (
    input  valid, status, block_index,
    output ready
  );
endinterface

`default_nettype wire

// ===== src/brtpl_span_cmp.sv =====
// Shared three-axis range comparator used by both box checks and point search.
`default_nettype none

module brtpl_span_cmp (
  input  brtpl_pkg::span_set_t spans_i,
  output logic                 all_in_o
);
  import brtpl_pkg::*;

  logic [AXES-1:0] axis_in;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      axis_in[a] = (spans_i[a].lo <= spans_i[a].val) && (spans_i[a].val <= spans_i[a].hi);
    end
  end

  assign all_in_o = &axis_in;
endmodule

`default_nettype wire

// ===== src/box_region_table_point_locate.sv =====
// An add item passes from its transfer through the add state and the done state to the
// output register. A locate item passes through the search state and the done state: the
// search walks the valid entries in circular order from the start index, one entry per
// cycle through the single read port of the box memory and one shared range comparator,
// and stops at the first box that holds the point. A start index not below the entry
// count skips the search and goes straight to the done state. The input is not ready while
// an item is in progress and becomes ready again as the result is loaded into the output
// register, so no new item is taken before the last one is through. A result waiting in
// the output register does not block the next input transfer, but that item then waits
// in its last state, with the input held off, until the register is free.
`default_nettype none
`include "box_region_table_point_locate_defines.svh"

module box_region_table_point_locate #(
  parameter int unsigned MAX_BLOCKS = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [brtpl_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [brtpl_pkg::GW-1:0]         cfg_data_i,
  brtpl_in_if.sink                        item_i,
  brtpl_out_if.source                     res_o
);
  import brtpl_pkg::*;

  localparam int unsigned CW   = (COORD_BITS < FW) ? COORD_BITS : FW;
  localparam int unsigned IW   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMPA = (CNTW > IW + 1) ? CNTW : IW + 1;
  localparam int unsigned CMPW = (CMPA > SIDX_W) ? CMPA : SIDX_W;
  localparam int unsigned EW   = 6 * CW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [CW-1:0] x_first;
    logic [CW-1:0] x_last;
    logic [CW-1:0] y_first;
    logic [CW-1:0] y_last;
    logic [CW-1:0] z_first;
    logic [CW-1:0] z_last;
  } box_t;

  state_e            state_q, state_d;
  logic [GW-1:0]     grid_x_q, grid_x_d;
  logic [GW-1:0]     grid_y_q, grid_y_d;
  logic [GW-1:0]     grid_z_q, grid_z_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic [IW-1:0]     cur_q, cur_d;
  logic [CNTW-1:0]   n_q, n_d;
  box_t              box_q, box_d;
  logic [CW-1:0]     px_q, px_d, py_q, py_d, pz_q, pz_d;
  logic [ST_W-1:0]   res_st_q, res_st_d;
  logic [IW-1:0]     res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;
  logic [BIDX_W-1:0] out_idx_q, out_idx_d;

  logic [EW-1:0]     mem [MAX_BLOCKS];
  logic [EW-1:0]     rdata_q;
  box_t              entry;
  logic              mem_we;

  span_set_t         spans;
  logic              span_ok;
  logic              grid_nz;
  logic              accept;
  logic [CMPW-1:0]   cur_inc;

  assign entry   = box_t'(rdata_q);
  assign accept  = item_i.valid && item_i.ready;
  assign grid_nz = (grid_x_q != '0) && (grid_y_q != '0) && (grid_z_q != '0);
  assign cur_inc = CMPW'(cur_q) + CMPW'(1);

  assign item_i.ready      = (state_q == S_IDLE);
  assign res_o.valid       = out_valid_q;
  assign res_o.status      = out_st_q;
  assign res_o.block_index = out_idx_q;

  // The comparator checks a new box against the grid in the add state and a stored
  // box against the point during the search.
  always_comb begin
    if (state_q == S_ADD) begin
      spans[0] = '{lo: GW'(box_q.x_first), val: GW'(box_q.x_last), hi: grid_x_q - GW'(1)};
      spans[1] = '{lo: GW'(box_q.y_first), val: GW'(box_q.y_last), hi: grid_y_q - GW'(1)};
      spans[2] = '{lo: GW'(box_q.z_first), val: GW'(box_q.z_last), hi: grid_z_q - GW'(1)};
    end else begin
      spans[0] = '{lo: GW'(entry.x_first), val: GW'(px_q), hi: GW'(entry.x_last)};
      spans[1] = '{lo: GW'(entry.y_first), val: GW'(py_q), hi: GW'(entry.y_last)};
      spans[2] = '{lo: GW'(entry.z_first), val: GW'(pz_q), hi: GW'(entry.z_last)};
    end
  end

  brtpl_span_cmp u_cmp (
    .spans_i  (spans),
    .all_in_o (span_ok)
  );

  always_comb begin
    state_d     = state_q;
    grid_x_d    = grid_x_q;
    grid_y_d    = grid_y_q;
    grid_z_d    = grid_z_q;
    count_d     = count_q;
    cur_d       = cur_q;
    n_d         = n_q;
    box_d       = box_q;
    px_d        = px_q;
    py_d        = py_q;
    pz_d        = pz_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_st_d    = out_st_q;
    out_idx_d   = out_idx_q;
    mem_we      = 1'b0;

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GRID_X: grid_x_d = cfg_data_i;
        REG_GRID_Y: grid_y_d = cfg_data_i;
        REG_GRID_Z: grid_z_d = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          box_d = '{x_first: item_i.box_x_first[CW-1:0], x_last: item_i.box_x_last[CW-1:0],
                    y_first: item_i.box_y_first[CW-1:0], y_last: item_i.box_y_last[CW-1:0],
                    z_first: item_i.box_z_first[CW-1:0], z_last: item_i.box_z_last[CW-1:0]};
          px_d  = item_i.point_x[CW-1:0];
          py_d  = item_i.point_y[CW-1:0];
          pz_d  = item_i.point_z[CW-1:0];
          cur_d = IW'(item_i.start_index);
          n_d   = '0;
          if (item_i.opcode == OP_ADD) begin
            state_d = S_ADD;
          end else if (CMPW'(item_i.start_index) >= CMPW'(count_q)) begin
            res_st_d  = ST_BAD_START;
            res_idx_d = '0;
            state_d   = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_ADD: begin
        res_idx_d = '0;
        if (!(span_ok && grid_nz)) begin
          res_st_d = ST_BAD_BOX;
        end else if (CMPW'(count_q) >= CMPW'(MAX_BLOCKS)) begin
          res_st_d = ST_FULL;
        end else begin
          mem_we    = 1'b1;
          res_idx_d = count_q[IW-1:0];
          res_st_d  = ST_OK;
          count_d   = count_q + CNTW'(1);
        end
        state_d = S_DONE;
      end
      S_SCAN: begin
        // The read data always belongs to cur_q: the read address follows cur_d.
        if (span_ok) begin
          res_st_d  = ST_OK;
          res_idx_d = cur_q;
          state_d   = S_DONE;
        end else if (n_q + CNTW'(1) == count_q) begin
          res_st_d  = ST_NOT_FOUND;
          res_idx_d = '0;
          state_d   = S_DONE;
        end else begin
          n_d   = n_q + CNTW'(1);
          cur_d = (cur_inc == CMPW'(count_q)) ? '0 : cur_inc[IW-1:0];
        end
      end
      S_DONE: begin
        if (!out_valid_q || res_o.ready) begin
          out_valid_d = 1'b1;
          out_st_d    = res_st_q;
          out_idx_d   = BIDX_W'(res_idx_q);
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      grid_x_q    <= GRID_RESET;
      grid_y_q    <= GRID_RESET;
      grid_z_q    <= GRID_RESET;
      count_q     <= '0;
      cur_q       <= '0;
      n_q         <= '0;
      box_q       <= '0;
      px_q        <= '0;
      py_q        <= '0;
      pz_q        <= '0;
      res_st_q    <= ST_OK;
      res_idx_q   <= '0;
      out_valid_q <= 1'b0;
      out_st_q    <= ST_OK;
      out_idx_q   <= '0;
    end else begin
      state_q     <= state_d;
      grid_x_q    <= grid_x_d;
      grid_y_q    <= grid_y_d;
      grid_z_q    <= grid_z_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      n_q         <= n_d;
      box_q       <= box_d;
      px_q        <= px_d;
      py_q        <= py_d;
      pz_q        <= pz_d;
      res_st_q    <= res_st_d;
      res_idx_q   <= res_idx_d;
      out_valid_q <= out_valid_d;
      out_st_q    <= out_st_d;
      out_idx_q   <= out_idx_d;
    end
  end

  // Box memory: one write port for adds, one registered read port for the search.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IW-1:0]] <= EW'(box_q);
    end
    rdata_q <= mem[cur_d];
  end

  `BRTPL_ASSERT_ALWAYS(a_count_max, clk_i, rst_ni, CMPW'(count_q) <= CMPW'(MAX_BLOCKS), "entry count beyond table size")
  `BRTPL_ASSERT_IMP(a_scan_cur, clk_i, rst_ni, state_q == S_SCAN, CMPW'(cur_q) < CMPW'(count_q), "search index outside valid entries")
  `BRTPL_ASSERT_IMP(a_scan_len, clk_i, rst_ni, state_q == S_SCAN, n_q < count_q, "search ran past the entry count")
  `BRTPL_ASSERT_NEXT(a_busy, clk_i, rst_ni, accept, state_q != S_IDLE, "accepted item left no work in progress")
endmodule

`default_nettype wire

// ===== tb/tb_box_region_table_point_locate.sv =====
// Box region table testbench: directed and random add/locate traffic checked by a predictor.
`timescale 1ns / 1ps

module tb_box_region_table_point_locate;
  import brtpl_pkg::*;

  localparam int unsigned TABLE_DEPTH    = 16;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PRESSURE_AT    = 250;
  localparam int unsigned PRESSURE_HOLD  = 300;
  localparam int unsigned DRAIN_CYCLES   = 24;
  localparam int unsigned REPORT_LIMIT   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic [FW-1:0] first [AXES];
    logic [FW-1:0] last [AXES];
  } box_t;

  typedef struct {
    logic              opcode;
    box_t              box;
    logic [FW-1:0]     point [AXES];
    logic [SIDX_W-1:0] start_index;
  } item_t;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [BIDX_W-1:0] block_index;
  } answer_t;

  // Keeps its own copy of the grid registers and the box table, predicts the answer to
  // every accepted item and compares the answers that come back in order.
  class box_table_scoreboard;
    logic [GW-1:0] grid [AXES];
    box_t          boxes [TABLE_DEPTH];
    int unsigned   box_count;
    answer_t       pending_answers [$];
    int unsigned   status_tally [5];
    int unsigned   mismatches;
    int unsigned   answers_checked;
    int unsigned   adds;
    int unsigned   locates;

    function new();
      foreach (grid[a]) grid[a] = GRID_RESET;
      foreach (status_tally[s]) status_tally[s] = 0;
      box_count = 0;
      mismatches = 0;
      answers_checked = 0;
      adds = 0;
      locates = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] index, logic [GW-1:0] value);
      case (index)
        REG_GRID_X: grid[0] = value;
        REG_GRID_Y: grid[1] = value;
        REG_GRID_Z: grid[2] = value;
        default: ;
      endcase
    endfunction

    function answer_t answer_for(item_t it);
      answer_t     ans;
      int unsigned cur;
      bit          fits;
      bit          inside_box;
      ans.status = ST_OK;
      ans.block_index = '0;
      if (it.opcode == OP_ADD) begin
        adds++;
        fits = 1'b1;
        for (int a = 0; a < AXES; a++) begin
          if (it.box.first[a] > it.box.last[a] || {1'b0, it.box.last[a]} >= grid[a])
            fits = 1'b0;
        end
        if (!fits) begin
          ans.status = ST_BAD_BOX;
        end else if (box_count >= TABLE_DEPTH) begin
          ans.status = ST_FULL;
        end else begin
          boxes[box_count] = it.box;
          ans.block_index = BIDX_W'(box_count);
          box_count++;
        end
      end else begin
        locates++;
        if (it.start_index >= box_count) begin
          ans.status = ST_BAD_START;
        end else begin
          ans.status = ST_NOT_FOUND;
          cur = 32'(it.start_index);
          for (int n = 0; n < box_count; n++) begin
            inside_box = 1'b1;
            for (int a = 0; a < AXES; a++) begin
              if (it.point[a] < boxes[cur].first[a] || it.point[a] > boxes[cur].last[a])
                inside_box = 1'b0;
            end
            // Only the first box met along the circular walk counts.
            if (ans.status == ST_NOT_FOUND && inside_box) begin
              ans.status = ST_OK;
              ans.block_index = BIDX_W'(cur);
            end
            cur = (cur + 1 == box_count) ? 0 : cur + 1;
          end
        end
      end
      return ans;
    endfunction

    function void log_request(item_t it);
      answer_t ans;
      ans = answer_for(it);
      status_tally[ans.status]++;
      pending_answers = {pending_answers, ans};
    endfunction

    function void compare_answer(logic [ST_W-1:0] status, logic [BIDX_W-1:0] block_index);
      answer_t want;
      answers_checked++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: none expected, got status %0d index %0d",
                   answers_checked, status, block_index);
        return;
      end
      want = pending_answers.pop_front();
      if (status !== want.status || block_index !== want.block_index) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("result %0d: expected status %0d index %0d, got status %0d index %0d",
                   answers_checked, want.status, want.block_index, status, block_index);
      end
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [GW-1:0]        cfg_data_i;

  brtpl_in_if  item_if ();
  brtpl_out_if res_if ();

  box_table_scoreboard tracker;
  int unsigned         items_sent = 0;
  int unsigned         results_taken = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         grid_settings = 1;

  box_region_table_point_locate dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_if.sink),
    .res_o       (res_if.source)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Ends the run if neither channel completes a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, stall-free stretches, and one long hold-off that backs the
  // block up until it refuses new items.
  initial begin : result_sink
    int unsigned hold;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = ((results_taken / 55) % 3 == 1) ? 0 : $urandom_range(0, 19);
      if (results_taken == PRESSURE_AT) hold = PRESSURE_HOLD;
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_if.valid) @(posedge clk_i);
      tracker.compare_answer(res_if.status, res_if.block_index);
      results_taken++;
      @(negedge clk_i);
    end
  end

  function automatic int cell_limit(logic [GW-1:0] g);
    if (g == 0) return -1;
    if (g > GRID_RESET) return 65535;
    return int'(g) - 1;
  endfunction

  // Fields that the opcode does not use are filled at random.
  function automatic item_t add_item(int x0, int x1, int y0, int y1, int z0, int z1);
    item_t it;
    it.opcode = OP_ADD;
    it.box.first[0] = x0[FW-1:0];
    it.box.last[0]  = x1[FW-1:0];
    it.box.first[1] = y0[FW-1:0];
    it.box.last[1]  = y1[FW-1:0];
    it.box.first[2] = z0[FW-1:0];
    it.box.last[2]  = z1[FW-1:0];
    foreach (it.point[a]) it.point[a] = FW'($urandom);
    it.start_index = SIDX_W'($urandom);
    return it;
  endfunction

  function automatic item_t locate_item(int px, int py, int pz, int start);
    item_t it;
    it.opcode = OP_LOCATE;
    foreach (it.point[a]) begin
      it.box.first[a] = FW'($urandom);
      it.box.last[a]  = FW'($urandom);
    end
    it.point[0] = px[FW-1:0];
    it.point[1] = py[FW-1:0];
    it.point[2] = pz[FW-1:0];
    it.start_index = start[SIDX_W-1:0];
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic offer_item(item_t it);
    int unsigned gap;
    gap = ((items_sent / 40) % 3 == 2) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_if.opcode      <= it.opcode;
    item_if.box_x_first <= it.box.first[0];
    item_if.box_x_last  <= it.box.last[0];
    item_if.box_y_first <= it.box.first[1];
    item_if.box_y_last  <= it.box.last[1];
    item_if.box_z_first <= it.box.first[2];
    item_if.box_z_last  <= it.box.last[2];
    item_if.point_x     <= it.point[0];
    item_if.point_y     <= it.point[1];
    item_if.point_z     <= it.point[2];
    item_if.start_index <= it.start_index;
    item_if.valid       <= 1'b1;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    tracker.log_request(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Waits until every predicted answer has come back.
  task automatic settle();
    item_if.valid <= 1'b0;
    while (tracker.pending_answers.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [GW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    tracker.set_register(index, value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Sets the grid, then mixes mostly well-formed adds and locates aimed at stored boxes
  // with unordered or out-of-grid boxes and stray points.
  task automatic run_random_phase(logic [GW-1:0] gx, logic [GW-1:0] gy, logic [GW-1:0] gz,
                                  int unsigned n);
    item_t       it;
    int          lim [AXES];
    int          lo;
    int          hi;
    int          span;
    int unsigned pick;
    settle();
    write_register(REG_GRID_X, gx);
    write_register(REG_GRID_Y, gy);
    write_register(REG_GRID_Z, gz);
    if ($urandom_range(0, 1) == 1) write_register(REG_NONE, GW'($urandom));
    grid_settings++;
    foreach (lim[a]) lim[a] = cell_limit(tracker.grid[a]);
    repeat (n) begin
      it.opcode = ($urandom_range(0, 99) < ((tracker.box_count < TABLE_DEPTH) ? 50 : 20))
                  ? OP_ADD : OP_LOCATE;
      for (int a = 0; a < AXES; a++) begin
        if (lim[a] >= 0 && $urandom_range(0, 99) < 85) begin
          lo = $urandom_range(0, lim[a]);
          case ($urandom_range(0, 3))
            0: span = $urandom_range(0, 15);
            1: span = $urandom_range(0, 1023);
            2: span = $urandom_range(0, 65535);
            default: span = lim[a];
          endcase
          hi = (lo + span > lim[a]) ? lim[a] : lo + span;
        end else begin
          lo = $urandom_range(0, 65535);
          hi = $urandom_range(0, 65535);
        end
        it.box.first[a] = lo[FW-1:0];
        it.box.last[a]  = hi[FW-1:0];
      end
      if (tracker.box_count > 0 && $urandom_range(0, 99) < 65) begin
        pick = $urandom_range(0, tracker.box_count - 1);
        for (int a = 0; a < AXES; a++) begin
          case ($urandom_range(0, 3))
            0: it.point[a] = tracker.boxes[pick].first[a];
            1: it.point[a] = tracker.boxes[pick].last[a];
            default: it.point[a] = FW'($urandom_range(tracker.boxes[pick].first[a],
                                                      tracker.boxes[pick].last[a]));
          endcase
        end
      end else begin
        foreach (it.point[a]) it.point[a] = FW'($urandom);
      end
      if (tracker.box_count > 0 && $urandom_range(0, 99) < 85)
        it.start_index = SIDX_W'($urandom_range(0, tracker.box_count - 1));
      else
        it.start_index = SIDX_W'($urandom_range(0, 15));
      offer_item(it);
    end
  endtask

  initial begin : stimulus
    tracker = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_GRID_X;
    cfg_data_i  = '0;
    item_if.valid       = 1'b0;
    item_if.opcode      = OP_ADD;
    item_if.box_x_first = '0;
    item_if.box_x_last  = '0;
    item_if.box_y_first = '0;
    item_if.box_y_last  = '0;
    item_if.box_z_first = '0;
    item_if.box_z_last  = '0;
    item_if.point_x     = '0;
    item_if.point_y     = '0;
    item_if.point_z     = '0;
    item_if.start_index = '0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty table, the widest box, unordered boxes on each axis and a corner box.
    offer_item(locate_item(0, 0, 0, 0));
    offer_item(locate_item(65535, 65535, 65535, 15));
    offer_item(add_item(0, 65535, 0, 65535, 0, 65535));
    offer_item(add_item(1, 0, 0, 0, 0, 0));
    offer_item(add_item(0, 0, 1, 0, 0, 0));
    offer_item(add_item(0, 0, 0, 0, 1, 0));
    offer_item(add_item(65535, 65535, 65535, 65535, 65535, 65535));
    offer_item(locate_item(0, 0, 0, 0));
    offer_item(locate_item(65535, 65535, 65535, 1));
    offer_item(locate_item(0, 0, 0, 2));
    settle();

    // One-cell x axis, oversized z register and a write to an unused index.
    write_register(REG_GRID_X, 17'd1);
    write_register(REG_GRID_Y, GRID_RESET);
    write_register(REG_GRID_Z, 17'h1FFFF);
    write_register(REG_NONE, 17'd5);
    grid_settings++;
    offer_item(add_item(0, 0, 5, 9, 100, 200));
    offer_item(add_item(0, 1, 5, 9, 100, 200));
    offer_item(locate_item(0, 7, 150, 2));
    offer_item(locate_item(0, 7, 150, 1));
    // The search wraps past the last entry back to the first.
    offer_item(locate_item(65535, 65535, 65535, 2));
    offer_item(add_item(0, 0, 0, 0, 65535, 65535));
    settle();

    // A zero-sized grid rejects every box, but points outside it are still searched.
    write_register(REG_GRID_X, 17'd0);
    grid_settings++;
    offer_item(add_item(0, 0, 0, 0, 0, 0));
    offer_item(locate_item(5, 5, 5, 3));

    run_random_phase(17'd512, 17'd300, 17'd64, 220);
    run_random_phase(17'd1, 17'd1, 17'd1, 120);
    run_random_phase(GRID_RESET, GRID_RESET, GRID_RESET, 200);
    run_random_phase(17'h1FFFF, GW'($urandom_range(1, 65536)), 17'd0, 160);
    run_random_phase(GW'($urandom_range(0, 17'h1FFFF)), GW'($urandom_range(0, 17'h1FFFF)),
                     GW'($urandom_range(0, 17'h1FFFF)), 200);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Sent %0d adds and %0d locates under %0d grid settings; the table holds %0d boxes.",
             tracker.adds, tracker.locates, grid_settings, tracker.box_count);
    $display("Answers: ok %0d, not found %0d, bad box %0d, full %0d, bad start %0d.",
             tracker.status_tally[ST_OK], tracker.status_tally[ST_NOT_FOUND],
             tracker.status_tally[ST_BAD_BOX], tracker.status_tally[ST_FULL],
             tracker.status_tally[ST_BAD_START]);
    if (tracker.mismatches == 0 && tracker.pending_answers.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatched results, %0d results missing", tracker.mismatches,
               tracker.pending_answers.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
